FILE: hw/rtl/maw_pkg.sv
// Shared types and constants for the B-spline mass assignment weight generator.
package maw_pkg;

  localparam int NUM_DIMS = 3;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_NEAREST = 2'd0,
    KIND_LINEAR  = 2'd1,
    KIND_QUAD    = 2'd2,
    KIND_CUBIC   = 2'd3
  } kind_t;

  localparam logic [2:0] REG_KIND    = 3'd0;
  localparam logic [2:0] REG_DMASK   = 3'd1;
  localparam logic [2:0] REG_SCALE0  = 3'd2;
  localparam logic [2:0] REG_SCALE1  = 3'd3;
  localparam logic [2:0] REG_SCALE2  = 3'd4;
  localparam logic [2:0] REG_OFFSET0 = 3'd5;
  localparam logic [2:0] REG_OFFSET1 = 3'd6;
  localparam logic [2:0] REG_OFFSET2 = 3'd7;

  // Classified coordinate, handed from the front end to the tap sequencer.
  typedef struct packed {
    kind_t              kind;
    logic               deriv;
    logic signed [31:0] sc;
    logic signed [15:0] bc;
    logic signed [19:0] dx;
  } entry_t;

  // Per-tap control that rides along the weight pipeline.
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic               deriv;
    logic signed [31:0] sc;
    logic signed [15:0] bc;
    logic [1:0]         tap;
    logic               last;
  } tag_t;

endpackage

FILE: hw/rtl/maw_front.sv
// Front end: configuration registers, grid mapping and cell classification.
module maw_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [39:0]     in_tdata,
  input  logic            q_full,
  output logic            q_push,
  output maw_pkg::entry_t q_entry
);
  import maw_pkg::*;

  kind_t              kind_r;
  logic [2:0]         dmask_r;
  logic signed [31:0] scale_r [3];
  logic signed [31:0] offset_r [3];

  logic [1:0]         dim;
  logic signed [31:0] coord;
  logic signed [31:0] sel_sc, sel_off;
  logic               sel_deriv, dim_ok;
  logic               adv, accept;

  logic               f1_v_r;
  logic signed [63:0] f1_prod_r;
  logic signed [31:0] f1_off_r, f1_sc_r;
  kind_t              f1_kind_r;
  logic               f1_deriv_r;

  logic               f2_v_r;
  logic signed [48:0] f2_g_r;
  logic signed [31:0] f2_sc_r;
  kind_t              f2_kind_r;
  logic               f2_deriv_r;

  logic signed [48:0] g_nxt;
  logic               odd, left;
  logic signed [49:0] h;
  logic signed [34:0] cell_idx;
  logic signed [15:0] bc;
  logic signed [19:0] dx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_LINEAR;
      dmask_r     <= 3'd0;
      scale_r[0]  <= 32'sd65536;
      scale_r[1]  <= 32'sd65536;
      scale_r[2]  <= 32'sd65536;
      offset_r[0] <= 32'sd0;
      offset_r[1] <= 32'sd0;
      offset_r[2] <= 32'sd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KIND:    kind_r      <= kind_t'(cfg_data[1:0]);
        REG_DMASK:   dmask_r     <= cfg_data[2:0];
        REG_SCALE0:  scale_r[0]  <= cfg_data;
        REG_SCALE1:  scale_r[1]  <= cfg_data;
        REG_SCALE2:  scale_r[2]  <= cfg_data;
        REG_OFFSET0: offset_r[0] <= cfg_data;
        REG_OFFSET1: offset_r[1] <= cfg_data;
        REG_OFFSET2: offset_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dim   = in_tdata[1:0];
  assign coord = in_tdata[33:2];
  assign dim_ok = (32'(dim) < NUM_DIMS);

  always_comb begin
    sel_sc    = scale_r[0];
    sel_off   = offset_r[0];
    sel_deriv = dmask_r[0];
    case (dim)
      2'd1: begin
        sel_sc    = scale_r[1];
        sel_off   = offset_r[1];
        sel_deriv = dmask_r[1];
      end
      2'd2: begin
        sel_sc    = scale_r[2];
        sel_off   = offset_r[2];
        sel_deriv = dmask_r[2];
      end
      default: ;
    endcase
  end

  // A waiting classified request blocks both stages until the queue has room.
  assign adv       = !f2_v_r || !q_full;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= accept && dim_ok;
      f2_v_r <= f1_v_r;
    end
  end

  assign g_nxt = 49'(f1_prod_r >>> 16) + 49'(f1_off_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_prod_r  <= coord * sel_sc;
      f1_off_r   <= sel_off;
      f1_sc_r    <= sel_sc;
      f1_kind_r  <= kind_r;
      f1_deriv_r <= sel_deriv;
      f2_g_r     <= g_nxt;
      f2_sc_r    <= f1_sc_r;
      f2_kind_r  <= f1_kind_r;
      f2_deriv_r <= f1_deriv_r;
    end
  end

  // Odd supports center on the cell, so the half-cell shift applies there.
  assign odd  = !f2_kind_r[0];
  assign left = f2_kind_r[1];
  assign h    = 50'(f2_g_r) + (odd ? 50'sd32768 : 50'sd0);
  assign cell_idx = 35'(h >>> 16) - (left ? 35'sd1 : 35'sd0);

  always_comb begin
    if (cell_idx > 35'sd32767)       bc = 16'sd32767;
    else if (cell_idx < -35'sd32768) bc = -16'sd32768;
    else                             bc = cell_idx[15:0];
  end

  assign dx = $signed({4'b0, h[15:0]}) - (odd ? 20'sd32768 : 20'sd0)
            + (left ? 20'sd65536 : 20'sd0);

  assign q_push        = f2_v_r && !q_full;
  assign q_entry.kind  = f2_kind_r;
  assign q_entry.deriv = f2_deriv_r;
  assign q_entry.sc    = f2_sc_r;
  assign q_entry.bc    = bc;
  assign q_entry.dx    = dx;

endmodule

FILE: hw/rtl/maw_queue.sv
// Small queue of classified coordinates between front end and tap sequencer.
module maw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  maw_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output maw_pkg::entry_t head,
  output logic            empty
);
  import maw_pkg::*;

  entry_t         mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r;
  logic           do_push, do_pop;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_entry;
  end

endmodule

FILE: hw/rtl/maw_back.sv
// Back end: tap sequencer and the pipelined kernel and derivative weight unit.
module maw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  maw_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [55:0]     out_tdata,
  output logic            out_tlast
);
  import maw_pkg::*;

  logic               adv, cur_last, free;
  logic               cur_v_r;
  entry_t             cur_r;
  logic [1:0]         tap_r;

  tag_t               t0_r, t1_r, t2_r, t3_r, t4_r, to_r;
  logic signed [19:0] s0_x_r;

  // Stage 1 fields.
  logic [17:0] s1_a_r, s1_u_r;
  logic        s1_inner_r, s1_outer_r, s1_near_r, s1_sgn_r, s1_zero_r;
  logic [19:0] x_abs;
  logic [17:0] a_c, u_c;
  logic        inner_c, outer_c;

  // Stage 2 fields.
  logic [35:0] s2_usq_r;
  logic [17:0] s2_a_r, s2_u_r;
  logic        s2_inner_r, s2_outer_r, s2_near_r, s2_sgn_r, s2_zero_r;

  // Stage 3 fields.
  logic [53:0]        s3_ucube_r;
  logic [35:0]        s3_usq_r;
  logic               s3_inner_r, s3_outer_r;
  logic signed [19:0] s3_d_r;
  logic [16:0]        s3_k_r;
  logic [18:0]        mag;
  logic [16:0]        k_c;
  logic [37:0]        m_cub;
  logic [36:0]        t_quad, t_out;

  // Stage 4 fields.
  logic [35:0]        s4_nm_r;
  logic signed [51:0] s4_p_r;
  logic [16:0]        s4_k_r;
  logic [53:0]        v_c, vr_c;

  // Output.
  logic signed [31:0] out_w_r;
  logic [51:0]        p_abs;
  logic [36:0]        p_rnd;
  logic signed [37:0] w_full;
  logic signed [31:0] w_c;

  assign adv      = !to_r.valid || out_tready;
  assign cur_last = (tap_r == cur_r.kind);
  assign free     = !cur_v_r || (adv && cur_last);
  assign q_pop    = free && !q_empty;

  // One tap leaves the sequencer in every cycle that the pipeline moves while a coordinate is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      tap_r   <= 2'd0;
    end else if (q_pop) begin
      cur_v_r <= 1'b1;
      tap_r   <= 2'd0;
    end else if (adv && cur_v_r) begin
      if (cur_last) cur_v_r <= 1'b0;
      else          tap_r   <= tap_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_r.valid <= 1'b0;
      t1_r.valid <= 1'b0;
      t2_r.valid <= 1'b0;
      t3_r.valid <= 1'b0;
      t4_r.valid <= 1'b0;
      to_r.valid <= 1'b0;
    end else if (adv) begin
      t0_r.valid <= cur_v_r;
      t1_r.valid <= t0_r.valid;
      t2_r.valid <= t1_r.valid;
      t3_r.valid <= t2_r.valid;
      t4_r.valid <= t3_r.valid;
      to_r.valid <= t4_r.valid;
      t0_r.kind  <= cur_r.kind;
      t0_r.deriv <= cur_r.deriv;
      t0_r.sc    <= cur_r.sc;
      t0_r.bc    <= cur_r.bc;
      t0_r.tap   <= tap_r;
      t0_r.last  <= cur_last;
      {t1_r.kind, t1_r.deriv, t1_r.sc, t1_r.bc, t1_r.tap, t1_r.last} <=
        {t0_r.kind, t0_r.deriv, t0_r.sc, t0_r.bc, t0_r.tap, t0_r.last};
      {t2_r.kind, t2_r.deriv, t2_r.sc, t2_r.bc, t2_r.tap, t2_r.last} <=
        {t1_r.kind, t1_r.deriv, t1_r.sc, t1_r.bc, t1_r.tap, t1_r.last};
      {t3_r.kind, t3_r.deriv, t3_r.sc, t3_r.bc, t3_r.tap, t3_r.last} <=
        {t2_r.kind, t2_r.deriv, t2_r.sc, t2_r.bc, t2_r.tap, t2_r.last};
      {t4_r.kind, t4_r.deriv, t4_r.sc, t4_r.bc, t4_r.tap, t4_r.last} <=
        {t3_r.kind, t3_r.deriv, t3_r.sc, t3_r.bc, t3_r.tap, t3_r.last};
      {to_r.kind, to_r.deriv, to_r.sc, to_r.bc, to_r.tap, to_r.last} <=
        {t4_r.kind, t4_r.deriv, t4_r.sc, t4_r.bc, t4_r.tap, t4_r.last};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s0_x_r <= cur_r.dx - $signed({2'b0, tap_r, 16'b0});
  end

  // Stage 1: magnitude and region; u is the distance that the region's
  // polynomial is written in.
  assign x_abs = s0_x_r[19] ? 20'(-s0_x_r) : 20'(s0_x_r);
  assign a_c   = x_abs[17:0];

  always_comb begin
    inner_c = 1'b0;
    outer_c = 1'b0;
    u_c     = a_c;
    unique case (t0_r.kind)
      KIND_NEAREST: ;
      KIND_LINEAR:  inner_c = (a_c < 18'd65536);
      KIND_QUAD: begin
        inner_c = (a_c <= 18'd32768);
        outer_c = !inner_c && (a_c < 18'd98304);
        if (!inner_c) u_c = 18'd98304 - a_c;
      end
      KIND_CUBIC: begin
        inner_c = (a_c < 18'd65536);
        outer_c = !inner_c && (a_c < 18'd131072);
        if (!inner_c) u_c = 18'd131072 - a_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r     <= a_c;
      s1_u_r     <= u_c;
      s1_inner_r <= inner_c;
      s1_outer_r <= outer_c;
      s1_near_r  <= (s0_x_r >= -20'sd32768) && (s0_x_r < 20'sd32768);
      s1_sgn_r   <= s0_x_r[19];
      s1_zero_r  <= (s0_x_r == 20'sd0);
    end
  end

  // Stage 2: square.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_usq_r   <= 36'(s1_u_r) * 36'(s1_u_r);
      s2_a_r     <= s1_a_r;
      s2_u_r     <= s1_u_r;
      s2_inner_r <= s1_inner_r;
      s2_outer_r <= s1_outer_r;
      s2_near_r  <= s1_near_r;
      s2_sgn_r   <= s1_sgn_r;
      s2_zero_r  <= s1_zero_r;
    end
  end

  // Stage 3: cube, derivative value and the low-order kernel values.
  assign m_cub  = (38'(s2_a_r) << 18) - 38'(s2_usq_r) * 38'd3 + 38'd65536;
  assign t_quad = 37'h0C0000000 - 37'(s2_usq_r) + 37'd32768;
  assign t_out  = 37'(s2_usq_r) + 37'd65536;

  always_comb begin
    mag = 19'd0;
    k_c = 17'd0;
    unique case (t2_r.kind)
      KIND_NEAREST: k_c = s2_near_r ? 17'd65536 : 17'd0;
      KIND_LINEAR: begin
        if (s2_inner_r) k_c = 17'd65536 - 17'(s2_a_r);
        if (s2_inner_r && !s2_zero_r) mag = 19'd65536;
      end
      KIND_QUAD: begin
        if (s2_inner_r) begin
          k_c = t_quad[32:16];
          mag = 19'(s2_a_r) << 1;
        end else if (s2_outer_r) begin
          k_c = t_out[33:17];
          mag = 19'(s2_u_r);
        end
      end
      KIND_CUBIC: begin
        if (s2_inner_r)      mag = m_cub[35:17];
        else if (s2_outer_r) mag = 19'(t_out[36:17]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ucube_r <= 54'(s2_usq_r) * 54'(s2_u_r);
      s3_usq_r   <= s2_usq_r;
      s3_inner_r <= s2_inner_r;
      s3_outer_r <= s2_outer_r;
      s3_d_r     <= s2_sgn_r ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
      s3_k_r     <= k_c;
    end
  end

  // Stage 4: cubic polynomial over 6 * 2^32, done as a shift and then a
  // divide by three through a reciprocal; derivative times scale.
  always_comb begin
    v_c = 54'd0;
    if (t3_r.kind == KIND_CUBIC) begin
      if (s3_inner_r)
        v_c = (54'd1 << 50) - 54'(s3_usq_r) * 54'd393216 + s3_ucube_r * 54'd3;
      else if (s3_outer_r)
        v_c = s3_ucube_r;
    end
  end

  assign vr_c = v_c + (54'd3 << 32);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_nm_r <= 36'(vr_c[50:33]) * 36'd174763;
      s4_p_r  <= 52'(s3_d_r) * 52'(t3_r.sc);
      s4_k_r  <= s3_k_r;
    end
  end

  // Output stage: round the product to nearest, ties away from zero, then
  // saturate.
  assign p_abs  = s4_p_r[51] ? 52'(-s4_p_r) : 52'(s4_p_r);
  assign p_rnd  = 37'((p_abs + 52'd32768) >> 16);
  assign w_full = s4_p_r[51] ? -$signed({1'b0, p_rnd}) : $signed({1'b0, p_rnd});

  always_comb begin
    if (!t4_r.deriv) begin
      if (t4_r.kind == KIND_CUBIC) w_c = $signed({15'b0, s4_nm_r[35:19]});
      else                          w_c = $signed({15'b0, s4_k_r});
    end else if (w_full > 38'sd2147483647) begin
      w_c = 32'sh7FFFFFFF;
    end else if (w_full < -38'sd2147483648) begin
      w_c = 32'sh80000000;
    end else begin
      w_c = w_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_w_r <= w_c;
  end

  assign out_tvalid = to_r.valid;
  assign out_tlast  = to_r.last;
  assign out_tdata  = {6'b0, out_w_r, to_r.tap, to_r.bc};

endmodule

FILE: hw/rtl/mass_assignment_weight_gen.sv
// Top level of the B-spline mass assignment weight generator.
//
// Input stream: one request per particle coordinate, in_tdata holds dim_sel
// and a Q16.16 coordinate. Requests with a dimension of three or more are
// taken and dropped without results. Output stream: one request per kernel
// tap (1 nearest, 2 linear, 3 quadratic, 4 cubic), carrying base cell, tap
// number and Q16.16 weight; out_tlast marks the final tap.
// The configuration port writes kernel kind, derivative mask, scales and
// offsets; it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. Throughput is one tap per
// cycle while the receiver is ready; the tap sequencer and its six-stage
// weight pipeline set that rate, and the sequencer takes the next coordinate
// from the queue as the last tap of the current one leaves.
// A four-entry queue sits between the mapping front end and the sequencer,
// so the input keeps flowing while results wait. When the receiver stalls
// the weight pipeline holds, the queue fills, and only then in_tready drops.
// Synchronous reset restores the register defaults (linear kernel, no
// derivative, unit scale, zero offset) and empties all stages.
module mass_assignment_weight_gen (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] dim_sel, [33:2] coordinate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] base_cell, [17:16] tap, [49:18] weight
  output logic        out_tlast
);
  import maw_pkg::*;

  entry_t push_entry, head_entry;
  logic   q_full, q_push, q_pop, q_empty;

  maw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  maw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (push_entry),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_entry),
    .empty    (q_empty)
  );

  maw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (head_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hw/rtl/maw_checker.sv
// Port-level checks for the weight generator, bound to the top level.
module maw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_ready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result request shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result request changed");

  a_tap3_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17:16] == 2'd3 |-> out_tlast)
    else $error("fourth tap not marked last");

  a_taps_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tdata[17:16] == $past(out_tdata[17:16]) + 2'd1
      && out_tdata[15:0] == $past(out_tdata[15:0]))
    else $error("taps of one coordinate not contiguous");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind mass_assignment_weight_gen maw_checker u_maw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_ready  (cfg_ready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: dv/tb_mass_assignment_weight_gen.sv
// Self-checking testbench for the B-spline mass assignment weight generator.
module tb_mass_assignment_weight_gen;
  import maw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    logic signed [15:0] base_cell;
    logic [1:0]         tap;
    logic signed [31:0] weight;
    logic               last;
  } tap_weight_t;

  class weight_scoreboard;
    kind_t           kind;
    logic [2:0]      dmask;
    longint          scale[3];
    longint          offset[3];
    tap_weight_t     expected_taps[$];
    int              errors;

    function new();
      kind = KIND_LINEAR;
      dmask = 3'b000;
      for (int d = 0; d < 3; d++) begin
        scale[d] = 65536;
        offset[d] = 0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_KIND:    kind = kind_t'(data[1:0]);
        REG_DMASK:   dmask = data[2:0];
        REG_SCALE0:  scale[0] = longint'($signed(data));
        REG_SCALE1:  scale[1] = longint'($signed(data));
        REG_SCALE2:  scale[2] = longint'($signed(data));
        REG_OFFSET0: offset[0] = longint'($signed(data));
        REG_OFFSET1: offset[1] = longint'($signed(data));
        default:     offset[2] = longint'($signed(data));
      endcase
    endfunction

    function longint round_up(longint m, int s);
      return (m + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint spline(longint x);
      longint a, t, a2;
      a = x < 0 ? -x : x;
      case (kind)
        KIND_NEAREST: return (x < 32768 && x >= -32768) ? 65536 : 0;
        KIND_LINEAR:  return a < 65536 ? 65536 - a : 0;
        KIND_QUAD: begin
          if (a <= 32768) return round_up((longint'(3) << 30) - a * a, 16);
          t = 98304 - a;
          if (a < 98304) return round_up(t * t, 17);
          return 0;
        end
        default: begin
          a2 = a * a;
          t = 131072 - a;
          if (a < 65536)
            return ((longint'(1) << 50) - 6 * a2 * 65536 + 3 * a2 * a +
                    (longint'(3) << 32)) / (longint'(6) << 32);
          if (a < 131072)
            return (t * t * t + (longint'(3) << 32)) / (longint'(6) << 32);
          return 0;
        end
      endcase
    endfunction

    function longint spline_slope(longint x);
      longint a, sgn, t;
      a = x < 0 ? -x : x;
      sgn = x < 0 ? -1 : 1;
      case (kind)
        KIND_NEAREST: return 0;
        KIND_LINEAR: begin
          if (x == 0 || a >= 65536) return 0;
          return x < 0 ? 65536 : -65536;
        end
        KIND_QUAD: begin
          if (a <= 32768) return -sgn * 2 * a;
          if (a < 98304) return -sgn * (98304 - a);
          return 0;
        end
        default: begin
          t = 131072 - a;
          if (a < 65536) return -sgn * round_up(4 * a * 65536 - 3 * a * a, 17);
          if (a < 131072) return -sgn * round_up(t * t, 17);
          return 0;
        end
      endcase
    endfunction

    // Queues the taps that one accepted coordinate must produce.
    function void note_coordinate(logic [1:0] dim, logic [31:0] coord);
      longint c, g, cidx, dx, x, w, p, sc;
      int support, left;
      tap_weight_t e;
      if (dim >= NUM_DIMS) return;
      support = int'(kind) + 1;
      left = (support - 1) / 2;
      sc = scale[dim];
      c = longint'($signed(coord));
      g = ((c * sc) >>> 16) + offset[dim];
      cidx = ((g + ((support % 2) ? 32768 : 0)) >>> 16) - left;
      dx = g - cidx * 65536;
      e.base_cell = cidx > 32767 ? 16'sd32767 :
                    (cidx < -32768 ? -16'sd32768 : cidx[15:0]);
      for (int i = 0; i < support; i++) begin
        x = dx - longint'(i) * 65536;
        if (dmask[dim]) begin
          p = spline_slope(x) * sc;
          w = p < 0 ? -round_up(-p, 16) : round_up(p, 16);
        end else begin
          w = spline(x);
        end
        if (w > 2147483647) w = 2147483647;
        if (w < -64'sd2147483648) w = -64'sd2147483648;
        e.tap = i[1:0];
        e.weight = w[31:0];
        e.last = (i + 1 == support);
        expected_taps.push_back(e);
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_tap(logic [55:0] data, logic last);
      tap_weight_t e;
      if (expected_taps.size() == 0) begin
        report($sformatf("unexpected tap data=%h last=%0b", data, last));
        return;
      end
      e = expected_taps.pop_front();
      if (data[15:0] !== e.base_cell)
        report($sformatf("base_cell %0d, want %0d", $signed(data[15:0]), e.base_cell));
      if (data[17:16] !== e.tap)
        report($sformatf("tap %0d, want %0d", data[17:16], e.tap));
      if (data[49:18] !== e.weight)
        report($sformatf("weight %0d, want %0d (tap %0d)", $signed(data[49:18]),
                         e.weight, e.tap));
      if (last !== e.last)
        report($sformatf("last_tap %0b, want %0b (tap %0d)", last, e.last, e.tap));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;

  weight_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_request;
  int hold_left;
  int cycles;

  mass_assignment_weight_gen dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_mass_assignment_weight_gen NOT OK");
      $finish;
    end
  end

  // Receiver: checks each tap and decides the next ready, including long holds.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_tvalid && out_tready) sb.check_tap(out_tdata, out_tlast);
      if (hold_request > 0 && hold_left == 0) begin
        hold_left <= hold_request;
        hold_request = 0;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_coordinate(logic [1:0] dim, logic [31:0] coord);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, coord, dim};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_coordinate(dim, coord);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.expected_taps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(kind_t kind, logic [2:0] dmask, logic [31:0] sc[3],
                             logic [31:0] off[3]);
    write_reg(REG_KIND, {30'd0, kind});
    write_reg(REG_DMASK, {29'd0, dmask});
    write_reg(REG_SCALE0, sc[0]);
    write_reg(REG_SCALE1, sc[1]);
    write_reg(REG_SCALE2, sc[2]);
    write_reg(REG_OFFSET0, off[0]);
    write_reg(REG_OFFSET1, off[1]);
    write_reg(REG_OFFSET2, off[2]);
  endtask

  // Mostly moderate values, sometimes a full-range word.
  function automatic logic [31:0] pick_q16(int span);
    int r;
    r = $urandom_range(9);
    if (r < 2) return $urandom;
    if (r == 2) return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'h8000};
    if (r == 3) return 32'($signed($urandom_range(2 * span)) - span) << 16;
    return 32'($signed($urandom_range(2 * span * 65536)) - span * 65536);
  endfunction

  function automatic logic [1:0] pick_dim();
    return ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
  endfunction

  logic [31:0] edge_coords[6] = '{32'h7fffffff, 32'h80000000, 32'h00000000,
                                  32'h00008000, 32'hffff0000, 32'h00018001};
  logic [31:0] sc_cfg[3];
  logic [31:0] off_cfg[3];

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cycles = 0;
    hold_request = 0;
    tx_idle_pct = 10;
    rx_idle_pct = 51;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every kernel with extreme coordinates; dim 1 runs the derivative
    // at full scale, dim 2 has its cell pushed past the range.
    for (int k = 0; k < 4; k++) begin
      sc_cfg = '{32'h00010000, 32'h7fffffff, 32'h80000000};
      off_cfg = '{32'h00000000, 32'h00000000, (k % 2) ? 32'h80000000 : 32'h7fffffff};
      load_config(kind_t'(k), 3'b010, sc_cfg, off_cfg);
      for (int i = 0; i < 6; i++) send_coordinate(2'((i + k) % 4), edge_coords[i]);
      stop_sending();
      wait_drained();
    end

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 10;
        rx_idle_pct = 51;
      end else if (ph < 8) begin
        tx_idle_pct = 51;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int d = 0; d < 3; d++) begin
        sc_cfg[d] = ($urandom_range(4) == 0) ? $urandom : pick_q16(4);
        off_cfg[d] = pick_q16(64);
      end
      if (ph == 11) begin
        sc_cfg = '{32'h80000000, 32'h7fffffff, 32'h00000000};
        off_cfg = '{32'h7fffffff, 32'h80000000, 32'h00000000};
      end
      load_config(kind_t'(ph % 4), 3'($urandom_range(7)), sc_cfg, off_cfg);
      for (int i = 0; i < 25; i++) begin
        if (ph == 9 && i == 2) hold_request = 200;
        if (ph == 5 && i == 12) begin
          stop_sending();
          while (sb.expected_taps.size() != 0) @(posedge clk);
        end
        send_coordinate(pick_dim(), pick_q16(($urandom_range(3) == 0) ? 30000 : 40));
      end
      stop_sending();
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("tb_mass_assignment_weight_gen OK");
    end else begin
      $display("tb_mass_assignment_weight_gen NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/maw_pkg.sv
hw/rtl/maw_front.sv
hw/rtl/maw_queue.sv
hw/rtl/maw_back.sv
hw/rtl/mass_assignment_weight_gen.sv
hw/rtl/maw_checker.sv
dv/tb_mass_assignment_weight_gen.sv
